@@ src/penalty_cache_backoff_top_macros.svh @@
// Assertion macros for the penalty cache RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef PENALTY_CACHE_BACKOFF_TOP_MACROS_SVH
`define PENALTY_CACHE_BACKOFF_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PCB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");
`define PCB_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: check failed");
`else
`define PCB_ASSERT(lbl, clk, rst_n, prop)
`define PCB_ASSERT_NR(lbl, clk, prop)
`endif
`endif

@@ src/pcb_pkg.sv @@
// Shared types, widths and codes for the penalty cache with backoff.
// No dependencies; used by the interfaces and all modules.
package pcb_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int KEY_BITS_DEF   = 32;

    localparam int PC_KEY_W   = 32;
    localparam int FUNC_W     = 2;
    localparam int REASON_W   = 8;
    localparam int RAND_W     = 8;
    localparam int VALUE_W    = 16;
    localparam int SLOT_OUT_W = 6;
    localparam int BUMP_W     = VALUE_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [FUNC_W-1:0] FN_PENALIZE  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_CLEAR     = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR_ALL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK    = 2'd2;

    localparam logic [VALUE_W-1:0] FLOOR_RST   = 16'd36;
    localparam logic [VALUE_W-1:0] CEILING_RST = 16'd60000;
    localparam logic [RAND_W-1:0]  MASK_RST    = 8'd15;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic need_scan;
        logic scan_done;
    } t_stat;

    typedef struct packed {
        logic                  blacklisted;
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot_used;
        logic                  load_hotcount;
        logic [VALUE_W-1:0]    new_value;
    } t_result;

endpackage

@@ src/pcb_in_if.sv @@
// Request channel: valid/ready handshake carrying one input word.
// Depends on pcb_pkg for field widths.
interface pcb_in_if;
    import pcb_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [PC_KEY_W-1:0] pc_key;
    logic [REASON_W-1:0] reason;
    logic [RAND_W-1:0]   random_bits;

    modport source (output valid, func, pc_key, reason, random_bits, input ready);
    modport sink   (input valid, func, pc_key, reason, random_bits, output ready);
endinterface

@@ src/pcb_out_if.sv @@
// Response channel: valid/ready handshake carrying one result word.
// Depends on pcb_pkg for field widths.
interface pcb_out_if;
    import pcb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  blacklisted;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot_used;
    logic                  load_hotcount;
    logic [VALUE_W-1:0]    new_value;

    modport source (output valid, blacklisted, hit, slot_used, load_hotcount, new_value,
                    input ready);
    modport sink   (input valid, blacklisted, hit, slot_used, load_hotcount, new_value,
                    output ready);
endinterface

@@ src/pcb_ctrl.sv @@
// Controller: sequences accept, slot scan and result hand-off.
// Depends on pcb_pkg; drives datapath commands, reads datapath status.
module pcb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  pcb_pkg::t_stat i_stat,
    output pcb_pkg::t_cmd  o_cmd
);
    import pcb_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.need_scan ? S_SCAN : S_RESULT;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_RESULT: begin
                o_cmd.emit = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ src/pcb_dpath.sv @@
// Datapath: slot memories, valid bits, scan pointer, backoff arithmetic,
// configuration registers and result registers. Depends on pcb_pkg.
`include "penalty_cache_backoff_top_macros.svh"
module pcb_dpath #(
    parameter int SLOT_COUNT = pcb_pkg::SLOT_COUNT_DEF,
    parameter int KEY_BITS   = pcb_pkg::KEY_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pcb_pkg::t_cmd                  i_cmd,
    output pcb_pkg::t_stat                 o_stat,
    input  logic [pcb_pkg::FUNC_W-1:0]     i_func,
    input  logic [pcb_pkg::PC_KEY_W-1:0]   i_pc_key,
    input  logic [pcb_pkg::REASON_W-1:0]   i_reason,
    input  logic [pcb_pkg::RAND_W-1:0]     i_random_bits,
    input  logic                           i_cfg_we,
    input  logic [pcb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pcb_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output pcb_pkg::t_result               o_result
);
    import pcb_pkg::*;

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    logic [FUNC_W-1:0]   r_func;
    logic [KEY_BITS-1:0] r_key;
    logic [REASON_W-1:0] r_reason;
    logic [RAND_W-1:0]   r_rnd;

    logic [VALUE_W-1:0] r_floor;
    logic [VALUE_W-1:0] r_ceil;
    logic [RAND_W-1:0]  r_mask;

    logic [KEY_BITS-1:0] mem_key [SLOT_COUNT];
    logic [VALUE_W-1:0]  mem_val [SLOT_COUNT];
    logic [REASON_W-1:0] mem_rsn [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_vld;

    logic [CW-1:0]       r_iss;
    logic                r_rd_vld;
    logic [AW-1:0]       r_rd_addr;
    logic [KEY_BITS-1:0] r_rd_key;
    logic [VALUE_W-1:0]  r_rd_val;
    logic                r_rd_ent_vld;

    logic [AW-1:0] r_next;
    logic          r_found;
    logic [AW-1:0] r_first;
    t_result       r_res;
    t_result       r_out;

    logic                w_rd_en;
    logic [AW-1:0]       w_rd_idx;
    logic [KEY_BITS-1:0] w_key_eff;
    logic [VALUE_W-1:0]  w_val_eff;
    logic                w_eval;
    logic                w_match;
    logic                w_last;
    logic                w_pen;
    logic [BUMP_W-1:0]   w_bump;
    logic                w_over;
    logic                w_done;
    logic                w_miss;
    logic                w_wr_en;
    logic                w_rsn_en;
    logic [AW-1:0]       w_wr_addr;
    logic [VALUE_W-1:0]  w_wr_val;
    t_result             w_res;

    assign o_stat.need_scan = (i_func == FN_PENALIZE) || (i_func == FN_CLEAR);
    assign o_stat.scan_done = w_done;

    assign w_rd_en   = i_cmd.scan && (r_iss < CW'(SLOT_COUNT));
    assign w_rd_idx  = r_iss[AW-1:0];
    assign w_key_eff = r_rd_ent_vld ? r_rd_key : '0;
    assign w_val_eff = r_rd_ent_vld ? r_rd_val : '0;
    assign w_eval    = i_cmd.scan && r_rd_vld;
    assign w_match   = w_eval && (w_key_eff == r_key);
    assign w_last    = w_eval && (r_rd_addr == AW'(SLOT_COUNT - 1));
    assign w_pen     = (r_func == FN_PENALIZE);
    assign w_bump    = (BUMP_W'(w_val_eff) << 1) + BUMP_W'(r_rnd & r_mask);
    assign w_over    = w_bump > BUMP_W'(r_ceil);
    assign w_miss    = w_pen && w_last && !w_match;
    assign w_done    = w_pen ? (w_match || w_last) : w_last;

    always_comb begin
        w_wr_en   = 1'b0;
        w_rsn_en  = 1'b0;
        w_wr_addr = r_rd_addr;
        w_wr_val  = r_floor;
        if (w_pen) begin
            if (w_match) begin
                w_wr_en  = !w_over;
                w_rsn_en = !w_over;
                w_wr_val = w_bump[VALUE_W-1:0];
            end else if (w_last) begin
                w_wr_en   = 1'b1;
                w_rsn_en  = 1'b1;
                w_wr_addr = r_next;
            end
        end else if (w_match) begin
            w_wr_en = 1'b1;
        end
    end

    always_comb begin
        w_res = '0;
        if (w_pen) begin
            if (w_match) begin
                w_res.blacklisted   = w_over;
                w_res.hit           = 1'b1;
                w_res.slot_used     = SLOT_OUT_W'(r_rd_addr);
                w_res.load_hotcount = !w_over;
                w_res.new_value     = w_over ? '0 : w_bump[VALUE_W-1:0];
            end else begin
                w_res.slot_used     = SLOT_OUT_W'(r_next);
                w_res.load_hotcount = 1'b1;
                w_res.new_value     = r_floor;
            end
        end else begin
            w_res.hit = r_found || w_match;
            if (r_found) begin
                w_res.slot_used = SLOT_OUT_W'(r_first);
            end else if (w_match) begin
                w_res.slot_used = SLOT_OUT_W'(r_rd_addr);
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= FLOOR_RST;
            r_ceil  <= CEILING_RST;
            r_mask  <= MASK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FLOOR:   r_floor <= i_cfg_wdata;
                CFG_CEILING: r_ceil  <= i_cfg_wdata;
                CFG_MASK:    r_mask  <= i_cfg_wdata[RAND_W-1:0];
                default:     ;
            endcase
        end
    end

    // capture the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_func;
            r_key    <= KEY_BITS'(i_pc_key);
            r_reason <= i_reason;
            r_rnd    <= i_random_bits;
        end
    end

    // slot memories: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_key[w_wr_addr] <= r_key;
            mem_val[w_wr_addr] <= w_wr_val;
        end
        if (w_rsn_en) begin
            mem_rsn[w_wr_addr] <= r_reason;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_key     <= mem_key[w_rd_idx];
            r_rd_val     <= mem_val[w_rd_idx];
            r_rd_ent_vld <= r_vld[w_rd_idx];
            r_rd_addr    <= w_rd_idx;
        end
    end

    // scan control, valid bits and round-robin pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_next   <= '0;
            r_iss    <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_iss    <= '0;
                r_rd_vld <= 1'b0;
                r_found  <= 1'b0;
                if (i_func == FN_CLEAR_ALL) begin
                    r_vld  <= '0;
                    r_next <= '0;
                end
            end else begin
                r_rd_vld <= w_rd_en;
                if (w_rd_en) begin
                    r_iss <= r_iss + CW'(1);
                end
                if (w_match && !r_found) begin
                    r_found <= 1'b1;
                end
                if (w_wr_en) begin
                    r_vld[w_wr_addr] <= 1'b1;
                end
                if (w_miss) begin
                    r_next <= (r_next == AW'(SLOT_COUNT - 1)) ? '0 : r_next + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_match && !r_found) begin
            r_first <= r_rd_addr;
        end
    end

    // result staging and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res <= '0;
        end else if (w_done) begin
            r_res <= w_res;
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    assign o_result = r_out;

    `PCB_ASSERT(a_write_in_scan, i_clk, i_rst_n, w_wr_en |-> i_cmd.scan)
    `PCB_ASSERT(a_blacklist_keeps, i_clk, i_rst_n, (w_pen && w_match && w_over) |-> !w_wr_en)
    `PCB_ASSERT(a_next_in_range, i_clk, i_rst_n, r_next <= AW'(SLOT_COUNT - 1))
    `PCB_ASSERT_NR(a_reset_empties, i_clk, !i_rst_n |=> (r_vld == '0 && r_next == '0))

endmodule

@@ src/penalty_cache_backoff_top.sv @@
// Penalty cache with randomized exponential backoff, top level.
// Depends on pcb_pkg, pcb_in_if, pcb_out_if, pcb_ctrl and pcb_dpath.
//
// One word at a time is processed. After a request word is accepted the
// block scans the slots in order, one slot per cycle through the single
// read port of the key/value memory. A penalize that hits stops the scan
// at the matching slot; a penalize miss and a clear walk every slot;
// clear-all and the unused function code skip the scan. A result that
// finds the previous one still waiting in the output register holds
// until that one is taken. The result sits in an output register, so the
// next request is accepted while the previous result waits. Slot
// emptiness is kept in per-slot valid bits, so neither reset nor clear-all
// needs a clearing pass. Configuration writes take effect at once and are
// to be issued only while the block is idle.
module penalty_cache_backoff_top #(
    parameter int SLOT_COUNT = pcb_pkg::SLOT_COUNT_DEF,
    parameter int KEY_BITS   = pcb_pkg::KEY_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pcb_in_if.sink                         i_req,
    pcb_out_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [pcb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pcb_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import pcb_pkg::*;

    t_cmd    w_cmd;
    t_stat   w_stat;
    t_result w_result;
    logic    w_in_ready;
    logic    w_out_valid;

    pcb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (w_out_valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pcb_dpath #(
        .SLOT_COUNT (SLOT_COUNT),
        .KEY_BITS   (KEY_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_func        (i_req.func),
        .i_pc_key      (i_req.pc_key),
        .i_reason      (i_req.reason),
        .i_random_bits (i_req.random_bits),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_result      (w_result)
    );

    assign i_req.ready         = w_in_ready;
    assign o_rsp.valid         = w_out_valid;
    assign o_rsp.blacklisted   = w_result.blacklisted;
    assign o_rsp.hit           = w_result.hit;
    assign o_rsp.slot_used     = w_result.slot_used;
    assign o_rsp.load_hotcount = w_result.load_hotcount;
    assign o_rsp.new_value     = w_result.new_value;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for penalty_cache_backoff_top: a penalty ledger class predicts
// each result word; plain tasks drive the request and configuration ports, a clocked block the response port.
// Depends on pcb_pkg, pcb_in_if, pcb_out_if and the RTL below penalty_cache_backoff_top.
module tb;
    import pcb_pkg::*;

    class penalty_ledger;
        logic [PC_KEY_W-1:0] keys [SLOT_COUNT_DEF];
        logic [VALUE_W-1:0]  values [SLOT_COUNT_DEF];
        logic [REASON_W-1:0] reasons [SLOT_COUNT_DEF];
        int                  next_slot;
        logic [VALUE_W-1:0]  floor_val;
        logic [VALUE_W-1:0]  ceil_val;
        logic [RAND_W-1:0]   mask_val;
        t_result             due[$];
        int                  miss_count;

        function new();
            empty_slots();
            floor_val  = FLOOR_RST;
            ceil_val   = CEILING_RST;
            mask_val   = MASK_RST;
            miss_count = 0;
        endfunction

        function void empty_slots();
            for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
                keys[i]    = '0;
                values[i]  = '0;
                reasons[i] = '0;
            end
            next_slot = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FLOOR:   floor_val = data[VALUE_W-1:0];
                CFG_CEILING: ceil_val = data[VALUE_W-1:0];
                CFG_MASK:    mask_val = data[RAND_W-1:0];
                default: ;
            endcase
        endfunction

        function int due_count();
            return due.size();
        endfunction

        function t_result apply_word(logic [FUNC_W-1:0] fn, logic [PC_KEY_W-1:0] key,
                                     logic [REASON_W-1:0] rsn, logic [RAND_W-1:0] rb);
            t_result     r;
            logic [31:0] bumped;
            bit          found;
            int          first;
            int          pick;
            r     = '0;
            found = 0;
            first = 0;
            case (fn)
                FN_PENALIZE: begin
                    for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
                        if (!found && keys[i] == key) begin
                            found = 1;
                            first = i;
                        end
                    end
                    if (found) begin
                        bumped      = {15'd0, values[first], 1'b0} + {24'd0, rb & mask_val};
                        r.hit       = 1'b1;
                        r.slot_used = SLOT_OUT_W'(first);
                        if (bumped > {16'd0, ceil_val}) begin
                            r.blacklisted = 1'b1;
                        end else begin
                            values[first]   = bumped[VALUE_W-1:0];
                            reasons[first]  = rsn;
                            r.load_hotcount = 1'b1;
                            r.new_value     = bumped[VALUE_W-1:0];
                        end
                    end else begin
                        pick            = next_slot;
                        next_slot       = (pick + 1 >= SLOT_COUNT_DEF) ? 0 : pick + 1;
                        keys[pick]      = key;
                        values[pick]    = floor_val;
                        reasons[pick]   = rsn;
                        r.slot_used     = SLOT_OUT_W'(pick);
                        r.load_hotcount = 1'b1;
                        r.new_value     = floor_val;
                    end
                end
                FN_CLEAR: begin
                    for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
                        if (keys[i] == key) begin
                            if (!found) first = i;
                            found     = 1;
                            values[i] = floor_val;
                        end
                    end
                    r.hit       = found;
                    r.slot_used = SLOT_OUT_W'(first);
                end
                FN_CLEAR_ALL: empty_slots();
                default: ;
            endcase
            return r;
        endfunction

        function void note_word(logic [FUNC_W-1:0] fn, logic [PC_KEY_W-1:0] key,
                                logic [REASON_W-1:0] rsn, logic [RAND_W-1:0] rb);
            due.push_back(apply_word(fn, key, rsn, rb));
        endfunction

        task report(string what);
            miss_count++;
            if (miss_count <= 40) $display("mismatch: %s", what);
        endtask

        task compare_field(string name, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
            if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_word(t_result got);
            t_result want;
            if (due.size() == 0) begin
                report($sformatf("result word %h with nothing outstanding", got));
            end else begin
                want = due.pop_front();
                compare_field("blacklisted", VALUE_W'(got.blacklisted),
                              VALUE_W'(want.blacklisted));
                compare_field("hit", VALUE_W'(got.hit), VALUE_W'(want.hit));
                compare_field("slot_used", VALUE_W'(got.slot_used),
                              VALUE_W'(want.slot_used));
                compare_field("load_hotcount", VALUE_W'(got.load_hotcount),
                              VALUE_W'(want.load_hotcount));
                compare_field("new_value", got.new_value, want.new_value);
            end
        endtask
    endclass

    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 170;
    localparam int WATCH_LIMIT = 2000;
    localparam int TAIL_CYCLES = SLOT_COUNT_DEF + 16;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    pcb_in_if  req_if ();
    pcb_out_if rsp_if ();

    penalty_ledger       ledger;
    bit                  idle_on;
    bit                  quiet;
    int                  stall_left;
    int                  dead_cycles;
    logic [PC_KEY_W-1:0] key_pool [0:95];
    int                  pool_size;

    penalty_cache_backoff_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                ledger.check_word(t_result'({rsp_if.blacklisted, rsp_if.hit, rsp_if.slot_used,
                                             rsp_if.load_hotcount, rsp_if.new_value}));
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 14);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (!req_if.valid && ledger.due_count() == 0)) begin
            dead_cycles = 0;
        end else begin
            dead_cycles++;
            if (dead_cycles >= WATCH_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [PC_KEY_W-1:0] key,
                             input logic [REASON_W-1:0] rsn, input logic [RAND_W-1:0] rb);
        if ($urandom_range(0, 39) == 0) quiet = !quiet;
        if (idle_on && !quiet && $urandom_range(0, 2) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.func        <= fn;
        req_if.pc_key      <= key;
        req_if.reason      <= rsn;
        req_if.random_bits <= rb;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        ledger.note_word(fn, key, rsn, rb);
    endtask

    task automatic send_random_word();
        int                  roll;
        logic [FUNC_W-1:0]   fn;
        logic [PC_KEY_W-1:0] key;
        roll = $urandom_range(0, 99);
        if (roll < 80)      fn = FN_PENALIZE;
        else if (roll < 95) fn = FN_CLEAR;
        else if (roll < 97) fn = FN_CLEAR_ALL;
        else                fn = FN_UNUSED;
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
            key = key_pool[$urandom_range(0, pool_size - 1)];
        end else if (roll < 99) begin
            key = $urandom;
            if (key == '0) key = 1;
        end else begin
            key = '0;
        end
        send_word(fn, key, REASON_W'($urandom_range(0, 255)), RAND_W'($urandom_range(0, 255)));
    endtask

    task automatic fill_pool();
        pool_size = $urandom_range(3, 90);
        for (int i = 0; i < pool_size; i++) begin
            key_pool[i] = $urandom;
            if (key_pool[i] == '0) key_pool[i] = 1;
        end
    endtask

    task automatic write_settings(input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi,
                                  input logic [RAND_W-1:0] msk);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_FLOOR;
        cfg_wdata <= lo;
        @(posedge i_clk);
        cfg_idx   <= CFG_CEILING;
        cfg_wdata <= hi;
        @(posedge i_clk);
        cfg_idx   <= CFG_MASK;
        cfg_wdata <= {8'd0, msk};
        @(posedge i_clk);
        cfg_we <= 1'b0;
        ledger.set_reg(CFG_FLOOR, lo);
        ledger.set_reg(CFG_CEILING, hi);
        ledger.set_reg(CFG_MASK, {8'd0, msk});
    endtask

    // drop valid and hold until every word has come back
    task automatic finish_phase();
        req_if.valid <= 1'b0;
        while (ledger.due_count() != 0) @(posedge i_clk);
    endtask

    initial begin
        ledger             = new();
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_wdata          = '0;
        req_if.valid       = 1'b0;
        req_if.func        = '0;
        req_if.pc_key      = '0;
        req_if.reason      = '0;
        req_if.random_bits = '0;
        rsp_if.ready       = 1'b0;
        idle_on            = 1'b1;
        quiet              = 1'b0;
        stall_left         = 0;
        dead_cycles        = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(FN_PENALIZE, 32'h1234_5678, 8'h00, 8'h00);
        send_word(FN_PENALIZE, 32'h1234_5678, 8'hFF, 8'hFF);
        send_word(FN_PENALIZE, 32'hFFFF_FFFF, 8'hA5, 8'h5A);
        send_word(FN_PENALIZE, 32'h0000_0001, 8'h5A, 8'hA5);
        send_word(FN_UNUSED, 32'h1234_5678, 8'h11, 8'h22);
        send_word(FN_PENALIZE, 32'h0000_0000, 8'h33, 8'hFF);
        send_word(FN_CLEAR, 32'h0000_0000, 8'h00, 8'h00);
        send_word(FN_CLEAR, 32'h1234_5678, 8'h00, 8'h00);
        send_word(FN_CLEAR, 32'hDEAD_BEEF, 8'h00, 8'h00);
        send_word(FN_PENALIZE, 32'h1234_5678, 8'h44, 8'h10);
        send_word(FN_CLEAR_ALL, 32'h1234_5678, 8'hFF, 8'hFF);
        send_word(FN_PENALIZE, 32'h1234_5678, 8'h55, 8'h01);
        finish_phase();

        write_settings(16'd100, 16'd500, 8'hFF);
        send_word(FN_PENALIZE, 32'hCAFE_0001, 8'h01, 8'h00);
        send_word(FN_PENALIZE, 32'hCAFE_0001, 8'h02, 8'hFF);
        send_word(FN_PENALIZE, 32'hCAFE_0001, 8'h03, 8'h00);
        send_word(FN_PENALIZE, 32'hCAFE_0001, 8'h04, 8'h00);
        send_word(FN_CLEAR, 32'hCAFE_0001, 8'h00, 8'h00);
        send_word(FN_PENALIZE, 32'hCAFE_0001, 8'h05, 8'h80);
        send_word(FN_PENALIZE, 32'h8000_0000, 8'hFF, 8'hFF);
        send_word(FN_CLEAR_ALL, 32'h0000_0000, 8'h00, 8'h00);
        finish_phase();

        for (int p = 0; p < PHASES; p++) begin
            idle_on = (p != PHASES - 1);
            case (p)
                0: write_settings(16'd1, 16'hFFFF, 8'hFF);
                1: write_settings(16'd0, 16'd0, 8'h00);
                2: write_settings(16'hFFFF, 16'hFFFF, 8'hFF);
                3: write_settings(16'hFFFF, 16'd0, 8'h80);
                4: write_settings(16'd0, 16'hFFFF, 8'h00);
                5: write_settings(16'd20, 16'd3000, 8'h07);
                6: write_settings(VALUE_W'($urandom_range(0, 300)),
                                  VALUE_W'($urandom_range(0, 65535)),
                                  RAND_W'($urandom_range(0, 255)));
                7: write_settings(VALUE_W'($urandom_range(0, 65535)),
                                  VALUE_W'($urandom_range(0, 65535)),
                                  RAND_W'($urandom_range(0, 255)));
                default: write_settings(FLOOR_RST, CEILING_RST, MASK_RST);
            endcase
            fill_pool();
            repeat (PHASE_ITEMS) send_random_word();
            finish_phase();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (ledger.miss_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

@@ penalty_cache_backoff_top.f @@
+incdir+src
src/pcb_pkg.sv
src/pcb_in_if.sv
src/pcb_out_if.sv
src/pcb_ctrl.sv
src/pcb_dpath.sv
src/penalty_cache_backoff_top.sv
tb/tb.sv
